FILE: rtl/tbc_pkg.sv
// ----------------------------------------------------------------------------
// Three-band crossover package
// Widths, register codes, controller types and saturation helpers.
// ----------------------------------------------------------------------------
package tbc_pkg;

	localparam int SAMPLE_BITS = 24;
	localparam int COEF_BITS   = 16;
	localparam int STATE_BITS  = 32;
	localparam int EXTRA_BITS  = STATE_BITS - SAMPLE_BITS;
	localparam int FRAC_BITS   = SAMPLE_BITS - 5;

	// Filter difference operand, coefficient product, shifted product and sum.
	localparam int OPND_BITS = STATE_BITS + 2;
	localparam int PROD_BITS = COEF_BITS + 1 + OPND_BITS;
	localparam int STEP_BITS = PROD_BITS - COEF_BITS;
	localparam int SUM_BITS  = STEP_BITS + 1;

	// High band and mid band after the return to sample scale.
	localparam int HIGH_BITS = OPND_BITS - EXTRA_BITS;
	localparam int MID_BITS  = SUM_BITS - EXTRA_BITS;
	localparam int MID_LIMIT = 10 * (2 ** FRAC_BITS);

	localparam int APB_ADDR_BITS = 3;
	localparam int APB_DATA_BITS = 32;

	typedef logic signed [SAMPLE_BITS-1:0] sample_t;
	typedef logic        [COEF_BITS-1:0]   coef_t;
	typedef logic signed [STATE_BITS-1:0]  state_t;
	typedef logic signed [OPND_BITS-1:0]   opnd_t;
	typedef logic signed [PROD_BITS-1:0]   prod_t;
	typedef logic signed [STEP_BITS-1:0]   step_t;
	typedef logic signed [SUM_BITS-1:0]    sum_t;
	typedef logic signed [HIGH_BITS-1:0]   high_t;
	typedef logic signed [MID_BITS-1:0]    mid_t;

	localparam coef_t LOW_COEF_RESET  = coef_t'(1693);
	localparam coef_t HIGH_COEF_RESET = coef_t'(21288);

	// Register index, taken from the word address.
	typedef enum logic [0:0] {
		REG_LOW_COEF  = 1'b0,
		REG_HIGH_COEF = 1'b1
	} reg_idx_t;

	typedef struct packed {
		coef_t low_coef;
		coef_t high_coef;
	} cfg_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_L1,
		ST_H1,
		ST_L2,
		ST_H2,
		ST_FIN,
		ST_WAIT
	} ctrl_state_t;

	// Which filter difference goes into the shared multiplier.
	typedef enum logic [1:0] {
		MUL_L1,
		MUL_H1,
		MUL_L2,
		MUL_H2
	} mul_sel_t;

	// Which stage memory takes the shifted product.
	typedef enum logic [1:0] {
		UPD_LS1,
		UPD_HS1,
		UPD_LS2,
		UPD_HS2
	} upd_sel_t;

	typedef struct packed {
		logic     load_x;
		logic     mul_en;
		mul_sel_t mul_sel;
		logic     upd_en;
		upd_sel_t upd_sel;
		logic     load_out;
	} dp_cmd_t;

	function automatic state_t sat_state(input sum_t v);
		state_t r;
		r = v[STATE_BITS-1:0];
		if ((v[SUM_BITS-1:STATE_BITS-1] != '0) && (v[SUM_BITS-1:STATE_BITS-1] != '1)) begin
			r = v[SUM_BITS-1] ? {1'b1, {(STATE_BITS-1){1'b0}}}
			                  : {1'b0, {(STATE_BITS-1){1'b1}}};
		end
		return r;
	endfunction

	function automatic sample_t sat_high(input high_t v);
		sample_t r;
		r = v[SAMPLE_BITS-1:0];
		if ((v[HIGH_BITS-1:SAMPLE_BITS-1] != '0) && (v[HIGH_BITS-1:SAMPLE_BITS-1] != '1)) begin
			r = v[HIGH_BITS-1] ? {1'b1, {(SAMPLE_BITS-1){1'b0}}}
			                   : {1'b0, {(SAMPLE_BITS-1){1'b1}}};
		end
		return r;
	endfunction

endpackage

FILE: rtl/tbc_if.sv
// ----------------------------------------------------------------------------
// Three-band crossover stream interfaces
// Valid/ready channels for the input sample and for the three band outputs.
// ----------------------------------------------------------------------------
interface tbc_in_if import tbc_pkg::*; ();
	logic    valid;
	logic    ready;
	sample_t sample_in;

	modport source (output valid, output sample_in, input ready);
	modport sink (input valid, input sample_in, output ready);
endinterface

interface tbc_out_if import tbc_pkg::*; ();
	logic    valid;
	logic    ready;
	sample_t low_band;
	sample_t mid_band;
	sample_t high_band;

	modport source (output valid, output low_band, output mid_band, output high_band,
		input ready);
	modport sink (input valid, input low_band, input mid_band, input high_band,
		output ready);
endinterface

FILE: rtl/tbc_cfg.sv
// ----------------------------------------------------------------------------
// Three-band crossover register file
// APB-style coefficient registers, one word each.
// ----------------------------------------------------------------------------
module tbc_cfg import tbc_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     psel,
	input  logic                     penable,
	input  logic                     pwrite,
	input  logic [APB_ADDR_BITS-1:0] paddr,
	input  logic [APB_DATA_BITS-1:0] pwdata,
	output logic [APB_DATA_BITS-1:0] prdata,
	output logic                     pready,
	output cfg_t                     cfg
);

	cfg_t     cfg_q;
	reg_idx_t idx;
	logic     wr_en;

	// Registers are word addressed; the byte offset bits are not decoded.
	assign idx    = reg_idx_t'(paddr[2]);
	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.low_coef  <= LOW_COEF_RESET;
			cfg_q.high_coef <= HIGH_COEF_RESET;
		end else if (wr_en) begin
			case (idx)
				REG_LOW_COEF:  cfg_q.low_coef  <= pwdata[COEF_BITS-1:0];
				REG_HIGH_COEF: cfg_q.high_coef <= pwdata[COEF_BITS-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_LOW_COEF:  prdata = APB_DATA_BITS'(cfg_q.low_coef);
			REG_HIGH_COEF: prdata = APB_DATA_BITS'(cfg_q.high_coef);
			default:       prdata = '0;
		endcase
	end

	assign cfg = cfg_q;

endmodule

FILE: rtl/tbc_ctrl.sv
// ----------------------------------------------------------------------------
// Three-band crossover controller
// Sequences the four shared-multiplier products and the result handoff.
// ----------------------------------------------------------------------------
module tbc_ctrl import tbc_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_ready,
	output logic    out_valid,
	input  logic    out_ready,
	output dp_cmd_t cmd
);

	ctrl_state_t state_q;
	ctrl_state_t state_nxt;
	logic        out_valid_q;
	logic        slot_free;

	// The result register can take a new item when empty or being emptied.
	assign slot_free = !out_valid_q || out_ready;

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: if (in_valid) state_nxt = ST_L1;
			ST_L1:   state_nxt = ST_H1;
			ST_H1:   state_nxt = ST_L2;
			ST_L2:   state_nxt = ST_H2;
			ST_H2:   state_nxt = ST_FIN;
			ST_FIN, ST_WAIT: begin
				if (!slot_free) begin
					state_nxt = ST_WAIT;
				end else if (in_valid) begin
					state_nxt = ST_L1;
				end else begin
					state_nxt = ST_IDLE;
				end
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: in_ready = 1'b1;
			ST_L1: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = MUL_L1;
			end
			ST_H1: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = MUL_H1;
				cmd.upd_en  = 1'b1;
				cmd.upd_sel = UPD_LS1;
			end
			ST_L2: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = MUL_L2;
				cmd.upd_en  = 1'b1;
				cmd.upd_sel = UPD_HS1;
			end
			ST_H2: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = MUL_H2;
				cmd.upd_en  = 1'b1;
				cmd.upd_sel = UPD_LS2;
			end
			ST_FIN: begin
				cmd.upd_en   = 1'b1;
				cmd.upd_sel  = UPD_HS2;
				cmd.load_out = slot_free;
				in_ready     = slot_free;
			end
			ST_WAIT: begin
				cmd.load_out = slot_free;
				in_ready     = slot_free;
			end
			default: ;
		endcase
		cmd.load_x = in_valid && in_ready;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

endmodule

FILE: rtl/tbc_dp.sv
// ----------------------------------------------------------------------------
// Three-band crossover datapath
// Stage memories, one shared coefficient multiplier, a saturating update
// adder and the result register.
// ----------------------------------------------------------------------------
module tbc_dp import tbc_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  dp_cmd_t cmd,
	input  cfg_t    cfg,
	input  sample_t sample_in,
	output sample_t low_band,
	output sample_t mid_band,
	output sample_t high_band
);

	state_t  x_q;
	state_t  ls1_q;
	state_t  ls2_q;
	state_t  hs1_q;
	state_t  hs2_q;
	opnd_t   h1_q;
	opnd_t   h2_q;
	prod_t   prod_q;
	sample_t low_q;
	sample_t mid_q;
	sample_t high_q;

	opnd_t   opnd;
	coef_t   coef_sel;
	step_t   step;
	state_t  upd_base;
	state_t  upd_val;
	sum_t    mid_diff;
	mid_t    mid_full;
	mid_t    mid_lim;
	sample_t mid_clamped;
	high_t   high_full;

	always_comb begin
		case (cmd.mul_sel)
			MUL_L1: begin
				opnd     = opnd_t'(x_q) - opnd_t'(ls1_q);
				coef_sel = cfg.low_coef;
			end
			MUL_H1: begin
				opnd     = opnd_t'(x_q) - opnd_t'(hs1_q);
				coef_sel = cfg.high_coef;
			end
			MUL_L2: begin
				opnd     = opnd_t'(ls1_q) - opnd_t'(ls2_q);
				coef_sel = cfg.low_coef;
			end
			MUL_H2: begin
				opnd     = h1_q - opnd_t'(hs2_q);
				coef_sel = cfg.high_coef;
			end
			default: begin
				opnd     = '0;
				coef_sel = '0;
			end
		endcase
	end

	// Dropping the low coefficient bits of a signed product is a floor shift.
	assign step = $signed(prod_q[PROD_BITS-1:COEF_BITS]);

	always_comb begin
		case (cmd.upd_sel)
			UPD_LS1: upd_base = ls1_q;
			UPD_HS1: upd_base = hs1_q;
			UPD_LS2: upd_base = ls2_q;
			UPD_HS2: upd_base = hs2_q;
			default: upd_base = '0;
		endcase
		upd_val = sat_state(sum_t'(upd_base) + sum_t'(step));
	end

	always_comb begin
		mid_diff  = sum_t'(x_q) - sum_t'(ls2_q) - sum_t'(h2_q);
		mid_full  = $signed(mid_diff[SUM_BITS-1:EXTRA_BITS]);
		mid_lim   = mid_t'(MID_LIMIT);
		high_full = $signed(h2_q[OPND_BITS-1:EXTRA_BITS]);
		if (mid_full > mid_lim) begin
			mid_clamped = sample_t'(mid_lim);
		end else if (mid_full < -mid_lim) begin
			mid_clamped = sample_t'(-mid_lim);
		end else begin
			mid_clamped = sample_t'(mid_full);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ls1_q <= '0;
			ls2_q <= '0;
			hs1_q <= '0;
			hs2_q <= '0;
		end else if (cmd.upd_en) begin
			case (cmd.upd_sel)
				UPD_LS1: ls1_q <= upd_val;
				UPD_HS1: hs1_q <= upd_val;
				UPD_LS2: ls2_q <= upd_val;
				UPD_HS2: hs2_q <= upd_val;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_x) begin
			x_q <= {sample_in, {EXTRA_BITS{1'b0}}};
		end
		if (cmd.mul_en) begin
			prod_q <= prod_t'($signed({1'b0, coef_sel})) * prod_t'(opnd);
			if (cmd.mul_sel == MUL_H1) begin
				h1_q <= opnd;
			end
			if (cmd.mul_sel == MUL_H2) begin
				h2_q <= opnd;
			end
		end
		if (cmd.load_out) begin
			low_q  <= ls2_q[STATE_BITS-1:EXTRA_BITS];
			mid_q  <= mid_clamped;
			high_q <= sat_high(high_full);
		end
	end

	assign low_band  = low_q;
	assign mid_band  = mid_q;
	assign high_band = high_q;

endmodule

FILE: rtl/three_band_crossover_splitter.sv
// ----------------------------------------------------------------------------
// Three-band crossover splitter
// Each accepted sample (signed Q4.19) yields one item of low, mid and high
// bands. Low is two cascaded one-pole lowpass stages on low_coef, high is two
// cascaded one-pole highpass stages on high_coef (both Q0.16, written over the
// APB-style port at byte addresses 0 and 4), and mid is the input minus both
// unsaturated bands, clamped to plus or minus 10.0. After acceptance one shared
// multiplier forms the four filter products in states L1, H1, L2 and H2; FIN
// applies the last memory update, and the result register is loaded in FIN, or
// in WAIT while the output side still holds the last result. The next item is
// accepted in the cycle its predecessor is loaded, not earlier. Coefficients
// must only change while the block is idle.
// ----------------------------------------------------------------------------
module three_band_crossover_splitter import tbc_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     psel,
	input  logic                     penable,
	input  logic                     pwrite,
	input  logic [APB_ADDR_BITS-1:0] paddr,
	input  logic [APB_DATA_BITS-1:0] pwdata,
	output logic [APB_DATA_BITS-1:0] prdata,
	output logic                     pready,
	tbc_in_if.sink                   in_ch,
	tbc_out_if.source                out_ch
);

	cfg_t    cfg;
	dp_cmd_t cmd;

	tbc_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	tbc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_ch.valid),
		.in_ready  (in_ch.ready),
		.out_valid (out_ch.valid),
		.out_ready (out_ch.ready),
		.cmd       (cmd)
	);

	tbc_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.cfg       (cfg),
		.sample_in (in_ch.sample_in),
		.low_band  (out_ch.low_band),
		.mid_band  (out_ch.mid_band),
		.high_band (out_ch.high_band)
	);

	// A result is never loaded over one that is still waiting.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> (!out_ch.valid || out_ch.ready))
		else $error("result register loaded while holding an untaken item");

	// A loaded result is presented in the next cycle.
	a_load_shows: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |=> out_ch.valid)
		else $error("loaded result not presented");

	// An accepted item starts with the first lowpass product.
	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_x |=> (cmd.mul_en && cmd.mul_sel == MUL_L1))
		else $error("accepted item did not start the filter sequence");

	// Acceptance never coincides with a multiplier step of the current item.
	a_accept_idle_mul: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_x |-> !cmd.mul_en)
		else $error("item accepted while products are in progress");

endmodule

FILE: tb/sv/tb_three_band_crossover_splitter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Three-band crossover splitter testbench
// Streams samples through the splitter under random idling on both sides and
// compares every band item with a mirror of the filter arithmetic. The mirror
// tracks its own filter memories and coefficients. Coefficients are rewritten
// between phases over the APB-style port, the extremes included.
// ----------------------------------------------------------------------------
module tb_three_band_crossover_splitter;
	import tbc_pkg::*;

	localparam longint SAMPLE_MAX = (longint'(1) <<< (SAMPLE_BITS - 1)) - 1;
	localparam longint SAMPLE_MIN = -SAMPLE_MAX - 1;
	localparam longint STATE_MAX  = (longint'(1) <<< (STATE_BITS - 1)) - 1;
	localparam longint STATE_MIN  = -STATE_MAX - 1;
	localparam longint MID_CAP    = longint'(MID_LIMIT);
	localparam int     PHASES     = 8;
	localparam int     PHASE_ITEMS = 120;
	localparam int     SETTLE_CYCLES = 8;
	localparam int     CYCLE_LIMIT = 400000;

	typedef struct packed {
		sample_t low;
		sample_t mid;
		sample_t high;
	} bands_t;

	class band_splitter_mirror;
		longint low_coef, high_coef;
		longint low_one, low_two, high_one, high_two;
		bands_t queued_bands[$];
		int     faults;

		function new();
			low_coef  = longint'(LOW_COEF_RESET);
			high_coef = longint'(HIGH_COEF_RESET);
			low_one   = 0;
			low_two   = 0;
			high_one  = 0;
			high_two  = 0;
			faults    = 0;
		endfunction

		function void set_coef(reg_idx_t idx, logic [APB_DATA_BITS-1:0] value);
			case (idx)
				REG_LOW_COEF: low_coef = longint'(value[COEF_BITS-1:0]);
				REG_HIGH_COEF: high_coef = longint'(value[COEF_BITS-1:0]);
				default: ;
			endcase
		endfunction

		function longint clip(longint v, longint lo, longint hi);
			if (v < lo)
				return lo;
			if (v > hi)
				return hi;
			return v;
		endfunction

		// Coefficient product, rounded toward minus infinity.
		function longint smooth(longint c, longint d);
			return (c * d) >>> COEF_BITS;
		endfunction

		function void flag(string msg);
			faults++;
			if (faults <= 10)
				$display("%s", msg);
		endfunction

		function void take_sample(sample_t s);
			longint x, l1, l2, h1, h2;
			bands_t b;
			x  = longint'(s) <<< EXTRA_BITS;
			l1 = clip(low_one + smooth(low_coef, x - low_one), STATE_MIN, STATE_MAX);
			l2 = clip(low_two + smooth(low_coef, l1 - low_two), STATE_MIN, STATE_MAX);
			low_one = l1;
			low_two = l2;
			h1 = x - high_one;
			high_one = clip(high_one + smooth(high_coef, h1), STATE_MIN, STATE_MAX);
			h2 = h1 - high_two;
			high_two = clip(high_two + smooth(high_coef, h2), STATE_MIN, STATE_MAX);
			// Mid uses the second low memory and the unsaturated high difference.
			b.low  = sample_t'(clip(l2 >>> EXTRA_BITS, SAMPLE_MIN, SAMPLE_MAX));
			b.high = sample_t'(clip(h2 >>> EXTRA_BITS, SAMPLE_MIN, SAMPLE_MAX));
			b.mid  = sample_t'(clip((x - l2 - h2) >>> EXTRA_BITS, -MID_CAP, MID_CAP));
			queued_bands.push_back(b);
		endfunction

		function void check_bands(sample_t low, sample_t mid, sample_t high);
			bands_t e;
			if (queued_bands.size() == 0) begin
				flag($sformatf("unexpected item: low %0d mid %0d high %0d", low, mid, high));
				return;
			end
			e = queued_bands.pop_front();
			if (e.low !== low || e.mid !== mid || e.high !== high)
				flag($sformatf("band mismatch: low %0d/%0d mid %0d/%0d high %0d/%0d (exp/got)",
					e.low, low, e.mid, mid, e.high, high));
		endfunction

		function void flush();
			if (queued_bands.size() != 0)
				flag($sformatf("%0d band items never arrived", queued_bands.size()));
		endfunction
	endclass

	logic                     clk = 1'b0;
	logic                     arst_n;
	logic                     psel;
	logic                     penable;
	logic                     pwrite;
	logic [APB_ADDR_BITS-1:0] paddr;
	logic [APB_DATA_BITS-1:0] pwdata;
	logic [APB_DATA_BITS-1:0] prdata;
	logic                     pready;

	tbc_in_if  in_ch ();
	tbc_out_if out_ch ();

	band_splitter_mirror mirror = new();
	int      cycles = 0;
	int      tx_calm = 0;
	int      rx_calm = 0;
	sample_t last_sample = '0;

	three_band_crossover_splitter DUT (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.in_ch   (in_ch),
		.out_ch  (out_ch)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// Wait in cycles before the next handshake, with runs of no waiting at all.
	function int draw_gap(inout int calm);
		if (calm > 0) begin
			calm--;
			return 0;
		end
		if ($urandom_range(0, 24) == 0) begin
			calm = $urandom_range(20, 80);
			return 0;
		end
		return $urandom_range(0, 16);
	endfunction

	function sample_t next_sample();
		int v;
		case ($urandom_range(0, 9))
			0, 1, 2, 3: last_sample = sample_t'($urandom);
			4: last_sample = $urandom_range(0, 1) ? sample_t'(SAMPLE_MAX) : sample_t'(SAMPLE_MIN);
			5, 6: begin
				v = $urandom_range(0, 2048);
				last_sample = sample_t'(v - 1024);
			end
			7: begin
				v = $urandom_range(0, 2 * MID_LIMIT);
				last_sample = sample_t'(v - MID_LIMIT);
			end
			default: ; // hold the last value to give the filters a step
		endcase
		return last_sample;
	endfunction

	task automatic push_sample(input sample_t s);
		int gap;
		gap = draw_gap(tx_calm);
		if (gap != 0) begin
			in_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_ch.valid     <= 1'b1;
		in_ch.sample_in <= s;
		do @(posedge clk); while (in_ch.ready !== 1'b1);
		mirror.take_sample(s);
	endtask

	// Stop sending and wait until every band item has come back.
	task automatic drain();
		in_ch.valid <= 1'b0;
		do @(posedge clk); while (mirror.queued_bands.size() != 0);
	endtask

	task automatic apb_write(input reg_idx_t idx, input logic [APB_DATA_BITS-1:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (pready !== 1'b1);
		mirror.set_coef(idx, value);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
	endtask

	initial begin : band_sink
		int stall;
		out_ch.ready = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			stall = draw_gap(rx_calm);
			if (stall != 0) begin
				out_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ch.ready <= 1'b1;
			do @(posedge clk); while (out_ch.valid !== 1'b1);
			mirror.check_bands(out_ch.low_band, out_ch.mid_band, out_ch.high_band);
		end
	end

	initial begin : stimulus
		sample_t opening[$];
		logic [APB_DATA_BITS-1:0] low_word, high_word;
		arst_n          = 1'b0;
		psel            = 1'b0;
		penable         = 1'b0;
		pwrite          = 1'b0;
		paddr           = '0;
		pwdata          = '0;
		in_ch.valid     = 1'b0;
		in_ch.sample_in = '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset coefficients: zero, extremes, unit steps and a full-scale square.
		opening = '{sample_t'(0), sample_t'(SAMPLE_MAX), sample_t'(SAMPLE_MAX),
			sample_t'(SAMPLE_MAX), sample_t'(SAMPLE_MIN), sample_t'(SAMPLE_MIN),
			sample_t'(-1), sample_t'(1), sample_t'(MID_LIMIT), sample_t'(-MID_LIMIT),
			sample_t'(SAMPLE_MAX), sample_t'(SAMPLE_MIN), sample_t'(SAMPLE_MAX),
			sample_t'(SAMPLE_MIN), sample_t'(0), sample_t'(0)};
		foreach (opening[i])
			push_sample(opening[i]);

		for (int p = 0; p < PHASES; p++) begin
			drain();
			repeat (SETTLE_CYCLES) @(posedge clk);
			// Upper bits of the written words are random or all ones and must be dropped.
			case (p)
				0: begin
					low_word  = $urandom & 32'hFFFF_0000;
					high_word = $urandom & 32'hFFFF_0000;
				end
				1: begin
					low_word  = 32'hFFFF_FFFF;
					high_word = 32'hFFFF_FFFF;
				end
				2: begin
					low_word  = ($urandom & 32'hFFFF_0000) | 32'd1;
					high_word = ($urandom & 32'hFFFF_0000) | 32'd65535;
				end
				3: begin
					low_word  = ($urandom & 32'hFFFF_0000) | 32'd65535;
					high_word = ($urandom & 32'hFFFF_0000) | 32'd1;
				end
				default: begin
					low_word  = $urandom;
					high_word = $urandom;
				end
			endcase
			apb_write(REG_LOW_COEF, low_word);
			apb_write(REG_HIGH_COEF, high_word);

			// With both coefficients at full scale a full-swing square drives
			// the second highpass memory into saturation.
			if (p == 1) begin
				for (int k = 0; k < 8; k++)
					push_sample(k[0] ? sample_t'(SAMPLE_MIN) : sample_t'(SAMPLE_MAX));
			end

			for (int i = 0; i < PHASE_ITEMS; i++) begin
				if (i == PHASE_ITEMS / 2)
					drain();
				push_sample(next_sample());
			end
		end

		drain();
		repeat (SETTLE_CYCLES * 2) @(posedge clk);
		mirror.flush();
		if (mirror.faults == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
